[src/ztf_pkg.sv]
package ztf_pkg;

  typedef enum logic [2:0] {
    CMD_FLAT   = 3'd0,
    CMD_TEX    = 3'd1,
    CMD_TEXEL  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_PRESET = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FLAT,
    OP_TEX,
    OP_TEXEL,
    OP_READ,
    OP_PRESET
  } op_e;

  localparam logic [2:0] REG_SCREEN_WIDTH   = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_TEXTURE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_TEXTURE_HEIGHT = 3'd3;

  localparam logic [10:0] RST_SCREEN_WIDTH   = 11'd640;
  localparam logic [10:0] RST_SCREEN_HEIGHT  = 11'd480;
  localparam logic [8:0]  RST_TEXTURE_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_TEXTURE_HEIGHT = 9'd256;

  localparam int unsigned BASE_W  = 22;
  localparam int unsigned STEP_W  = 49;
  localparam int unsigned ACC_W   = 50;
  localparam int unsigned DIV_DW  = 49;
  localparam int unsigned DIV_VW  = 32;
  localparam int unsigned Q_DEPTH = 2;

  typedef struct packed {
    logic [2:0]         command;
    logic [9:0]         x_start;
    logic [9:0]         x_end;
    logic [9:0]         row;
    logic signed [31:0] z_start;
    logic signed [31:0] z_end;
    logic signed [31:0] u_start;
    logic signed [31:0] u_end;
    logic signed [31:0] v_start;
    logic signed [31:0] v_end;
    logic [31:0]        color;
    logic [1:0]         texture_slot;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        pixel_color;
    logic signed [31:0] pixel_depth;
    logic [10:0]        pixels_written;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic [10:0] sw;
    logic [10:0] sh;
    logic [8:0]  tw;
    logic [8:0]  th;
  } cfg_t;

  typedef struct packed {
    op_e                       op;
    logic                      clip;
    logic [9:0]                lo;
    logic [9:0]                hi;
    logic [9:0]                row;
    logic [BASE_W-1:0]         base;
    logic signed [31:0]        z0;
    logic signed [31:0]        u0;
    logic signed [31:0]        v0;
    logic signed [STEP_W-1:0]  zs;
    logic signed [STEP_W-1:0]  us;
    logic signed [STEP_W-1:0]  vs;
    logic [31:0]               color;
    logic [1:0]                slot;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DSTART,
    F_DWAIT,
    F_PUSH
  } f_state_e;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_FETCH,
    B_RUN,
    B_RWAIT,
    B_PIX,
    B_TEST,
    B_MULU,
    B_DSU,
    B_WU,
    B_MULV,
    B_DSV,
    B_WV,
    B_TEXRD,
    B_TEXWR,
    B_ADV,
    B_DONE
  } b_state_e;

  function automatic logic [10:0] clamp_cfg(logic [10:0] v, int unsigned hi);
    logic [10:0] r;
    if (v == 11'd0) begin
      r = 11'd1;
    end else if (32'(v) > hi) begin
      r = 11'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[src/ztf_ram.sv]
module ztf_ram #(
  parameter int unsigned W  = 32,
  parameter int unsigned D  = 16,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/ztf_div.sv]
module ztf_div #(
  parameter int unsigned DW = 49,
  parameter int unsigned VW = 32,
  localparam int unsigned CW = $clog2(DW + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] a_i,
  input  logic signed [VW-1:0] b_i,
  output logic                 done_o,
  output logic signed [DW-1:0] q_o
);

  logic          run_q, done_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q, amag;
  logic [VW:0]   rem_q, shifted, rem_d;
  logic [VW-1:0] bmag_q, bmag;
  logic          fits;

  assign amag    = a_i[DW-1] ? (~a_i + 1'b1) : a_i;
  assign bmag    = b_i[VW-1] ? (~b_i + 1'b1) : b_i;
  assign shifted = {rem_q[VW-1:0], quo_q[DW-1]};
  assign fits    = shifted >= {1'b0, bmag_q};
  assign rem_d   = fits ? (shifted - {1'b0, bmag_q}) : shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      bmag_q <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      neg_q  <= a_i[DW-1] ^ b_i[VW-1];
      cnt_q  <= '0;
      quo_q  <= amag;
      rem_q  <= '0;
      bmag_q <= bmag;
    end else if (run_q) begin
      quo_q <= {quo_q[DW-2:0], fits};
      rem_q <= rem_d;
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign q_o    = neg_q ? $signed(~quo_q + 1'b1) : $signed(quo_q);

endmodule

[src/ztf_fifo.sv]
module ztf_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o
);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_q];
  assign full_o  = cnt_q == (PW + 1)'(DEPTH);
  assign empty_o = cnt_q == '0;

endmodule

[src/ztf_front.sv]
module ztf_front import ztf_pkg::*; #(
  parameter int unsigned TEXTURE_SLOTS = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     enable_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     push_o,
  input  logic     full_i,
  output job_t     job_o
);

  f_state_e state_q, state_d;
  job_t     job_q, acc_job;
  logic signed [31:0] ze_q, ue_q, ve_q;
  logic [9:0] n_q;
  logic [1:0] idx_q;

  logic swap, is_span, slot_bad;
  logic [10:0] y, mrow;
  logic [21:0] prod;

  logic div_start, div_done;
  logic signed [31:0] sel_e, sel_s;
  logic signed [32:0] diff;
  logic signed [DIV_DW-1:0] div_a, div_q;
  logic signed [DIV_VW-1:0] div_b;

  always_comb begin
    swap     = in_data_i.x_start > in_data_i.x_end;
    is_span  = (in_data_i.command == CMD_FLAT) || (in_data_i.command == CMD_TEX);
    slot_bad = {30'b0, in_data_i.texture_slot} >= TEXTURE_SLOTS;
    y        = cfg_i.sh - {1'b0, in_data_i.row} - 11'd1;
    mrow     = is_span ? y : {1'b0, in_data_i.row};
    prod     = mrow * cfg_i.sw;

    acc_job       = '0;
    acc_job.op    = OP_NONE;
    acc_job.lo    = swap ? in_data_i.x_end : in_data_i.x_start;
    acc_job.hi    = swap ? in_data_i.x_start : in_data_i.x_end;
    acc_job.row   = in_data_i.row;
    acc_job.base  = BASE_W'(prod);
    acc_job.z0    = swap ? in_data_i.z_end : in_data_i.z_start;
    acc_job.u0    = swap ? in_data_i.u_end : in_data_i.u_start;
    acc_job.v0    = swap ? in_data_i.v_end : in_data_i.v_start;
    acc_job.color = in_data_i.color;
    acc_job.slot  = in_data_i.texture_slot;
    if (!is_span) begin
      acc_job.lo = in_data_i.x_start;
      acc_job.z0 = in_data_i.z_start;
    end

    case (in_data_i.command)
      CMD_FLAT, CMD_TEX: begin
        if (in_data_i.command == CMD_TEX && slot_bad) begin
          acc_job.clip = 1'b1;
        end else if ({1'b0, in_data_i.row} >= cfg_i.sh) begin
          acc_job.clip = 1'b1;
        end else begin
          acc_job.op = (in_data_i.command == CMD_TEX) ? OP_TEX : OP_FLAT;
        end
      end
      CMD_TEXEL: begin
        if (slot_bad || {1'b0, in_data_i.x_start} >= {1'b0, cfg_i.tw}
            || {1'b0, in_data_i.row} >= {1'b0, cfg_i.th}) begin
          acc_job.clip = 1'b1;
        end else begin
          acc_job.op = OP_TEXEL;
        end
      end
      CMD_READ, CMD_PRESET: begin
        if ({1'b0, in_data_i.x_start} >= cfg_i.sw || {1'b0, in_data_i.row} >= cfg_i.sh) begin
          acc_job.clip = 1'b1;
        end else begin
          acc_job.op = (in_data_i.command == CMD_READ) ? OP_READ : OP_PRESET;
        end
      end
      default: begin
        acc_job.op = OP_NONE;
      end
    endcase
  end

  always_comb begin
    unique case (idx_q)
      2'd0:    begin sel_e = ze_q; sel_s = job_q.z0; end
      2'd1:    begin sel_e = ue_q; sel_s = job_q.u0; end
      default: begin sel_e = ve_q; sel_s = job_q.v0; end
    endcase
    diff  = 33'(sel_e) - 33'(sel_s);
    div_a = {diff, 16'b0};
    div_b = $signed({22'b0, n_q});
  end

  ztf_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i && enable_i) begin
          if ((acc_job.op == OP_FLAT || acc_job.op == OP_TEX) && acc_job.lo != acc_job.hi) begin
            state_d = F_DSTART;
          end else begin
            state_d = F_PUSH;
          end
        end
      end
      F_DSTART: state_d = F_DWAIT;
      F_DWAIT: begin
        if (div_done) begin
          state_d = (idx_q == 2'd2) ? F_PUSH : F_DSTART;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == F_IDLE) && enable_i;
    div_start  = state_q == F_DSTART;
    push_o     = (state_q == F_PUSH) && !full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      job_q   <= '0;
      ze_q    <= '0;
      ue_q    <= '0;
      ve_q    <= '0;
      n_q     <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_ready_o && in_valid_i) begin
        job_q <= acc_job;
        ze_q  <= swap ? in_data_i.z_start : in_data_i.z_end;
        ue_q  <= swap ? in_data_i.u_start : in_data_i.u_end;
        ve_q  <= swap ? in_data_i.v_start : in_data_i.v_end;
        n_q   <= acc_job.hi - acc_job.lo;
        idx_q <= '0;
      end else if (state_q == F_DWAIT && div_done) begin
        unique case (idx_q)
          2'd0:    job_q.zs <= div_q;
          2'd1:    job_q.us <= div_q;
          default: job_q.vs <= div_q;
        endcase
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  assign job_o = job_q;

endmodule

[src/ztf_back.sv]
module ztf_back import ztf_pkg::*; #(
  parameter int unsigned MAX_SCREEN_WIDTH  = 1024,
  parameter int unsigned MAX_SCREEN_HEIGHT = 1024,
  parameter int unsigned TEXTURE_SLOTS     = 4,
  parameter int unsigned MAX_TEXTURE_SIDE  = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      empty_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      clear_done_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned SCREEN_WORDS = MAX_SCREEN_WIDTH * MAX_SCREEN_HEIGHT;
  localparam int unsigned SAW = $clog2(SCREEN_WORDS);
  localparam int unsigned TEX_WORDS = TEXTURE_SLOTS * MAX_TEXTURE_SIDE * MAX_TEXTURE_SIDE;
  localparam int unsigned TAW = $clog2(TEX_WORDS);
  localparam int unsigned TCW = $clog2(MAX_TEXTURE_SIDE);

  b_state_e state_q, state_d;
  job_t     job_q;
  logic [9:0] x_q;
  logic signed [ACC_W-1:0] za_q, ua_q, va_q;
  logic [10:0] cnt_q;
  logic clip_q;
  logic [TCW-1:0] tu_q, tv_q;
  logic signed [DIV_DW-1:0] opa_q;
  logic [31:0] rc_q;
  logic signed [31:0] rd_q;
  logic [SAW-1:0] clr_q;
  logic out_valid_q;
  out_item_t out_q;

  logic signed [31:0] zp, up, vp;
  logic [SAW-1:0] pos;
  logic [8:0] tw_m1, th_m1;
  logic signed [DIV_DW-1:0] tw_lim, th_lim;
  logic signed [32:0] zmv;
  logic signed [42:0] prod_u, prod_v;
  logic [TAW-1:0] tex_raddr, tex_waddr;
  logic out_load;

  logic depth_we, color_we, tex_we;
  logic [SAW-1:0] scr_waddr, scr_raddr;
  logic [31:0] depth_wdata, color_wdata, depth_rdata, color_rdata, tex_rdata;

  logic div_start, div_done;
  logic signed [DIV_DW-1:0] div_q;

  assign zp     = za_q[47:16];
  assign up     = ua_q[47:16];
  assign vp     = va_q[47:16];
  assign pos    = SAW'(32'(job_q.base) + 32'(x_q));
  assign tw_m1  = cfg_i.tw - 9'd1;
  assign th_m1  = cfg_i.th - 9'd1;
  assign tw_lim = $signed(DIV_DW'(tw_m1));
  assign th_lim = $signed(DIV_DW'(th_m1));
  assign zmv    = 33'(zp) - 33'(vp);
  assign prod_u = 43'(up) * 43'($signed({1'b0, tw_m1}));
  assign prod_v = 43'(zmv) * 43'($signed({1'b0, th_m1}));
  assign tex_raddr = TAW'((32'(job_q.slot) * MAX_TEXTURE_SIDE + 32'(tv_q))
                          * MAX_TEXTURE_SIDE + 32'(tu_q));
  assign tex_waddr = TAW'((32'(job_q.slot) * MAX_TEXTURE_SIDE + 32'(job_q.row))
                          * MAX_TEXTURE_SIDE + 32'(job_q.lo));

  ztf_ram #(.W(32), .D(SCREEN_WORDS)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (depth_we),
    .waddr_i (scr_waddr),
    .wdata_i (depth_wdata),
    .raddr_i (scr_raddr),
    .rdata_o (depth_rdata)
  );

  ztf_ram #(.W(32), .D(SCREEN_WORDS)) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (color_we),
    .waddr_i (scr_waddr),
    .wdata_i (color_wdata),
    .raddr_i (scr_raddr),
    .rdata_o (color_rdata)
  );

  ztf_ram #(.W(32), .D(TEX_WORDS)) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (tex_we),
    .waddr_i (tex_waddr),
    .wdata_i (job_q.color),
    .raddr_i (tex_raddr),
    .rdata_o (tex_rdata)
  );

  ztf_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (opa_q),
    .b_i     (zp),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR: begin
        if (clr_q == SAW'(SCREEN_WORDS - 1)) begin
          state_d = B_FETCH;
        end
      end
      B_FETCH: begin
        if (!empty_i) begin
          state_d = B_RUN;
        end
      end
      B_RUN: begin
        unique case (job_q.op)
          OP_READ:         state_d = B_RWAIT;
          OP_FLAT, OP_TEX: state_d = B_PIX;
          default:         state_d = B_DONE;
        endcase
      end
      B_RWAIT: state_d = B_DONE;
      B_PIX: begin
        state_d = ({1'b0, x_q} >= cfg_i.sw) ? B_ADV : B_TEST;
      end
      B_TEST: begin
        if ($signed(depth_rdata) < zp) begin
          if (job_q.op == OP_FLAT) begin
            state_d = B_ADV;
          end else if (zp == 32'sd0) begin
            state_d = B_TEXRD;
          end else begin
            state_d = B_MULU;
          end
        end else begin
          state_d = B_ADV;
        end
      end
      B_MULU: state_d = B_DSU;
      B_DSU:  state_d = B_WU;
      B_WU: begin
        if (div_done) begin
          state_d = B_MULV;
        end
      end
      B_MULV: state_d = B_DSV;
      B_DSV:  state_d = B_WV;
      B_WV: begin
        if (div_done) begin
          state_d = B_TEXRD;
        end
      end
      B_TEXRD: state_d = B_TEXWR;
      B_TEXWR: state_d = B_ADV;
      B_ADV: begin
        state_d = (x_q == job_q.hi) ? B_DONE : B_PIX;
      end
      B_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = B_FETCH;
        end
      end
      default: state_d = B_FETCH;
    endcase
  end

  always_comb begin
    depth_we    = 1'b0;
    color_we    = 1'b0;
    tex_we      = 1'b0;
    scr_waddr   = pos;
    scr_raddr   = pos;
    depth_wdata = zp;
    color_wdata = job_q.color;
    div_start   = 1'b0;
    pop_o       = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      B_CLEAR: begin
        depth_we    = 1'b1;
        color_we    = 1'b1;
        scr_waddr   = clr_q;
        depth_wdata = '0;
        color_wdata = '0;
      end
      B_FETCH: pop_o = !empty_i;
      B_RUN: begin
        if (job_q.op == OP_PRESET) begin
          depth_we    = 1'b1;
          color_we    = 1'b1;
          depth_wdata = job_q.z0;
        end
        tex_we = job_q.op == OP_TEXEL;
      end
      B_TEST: begin
        if ($signed(depth_rdata) < zp && job_q.op == OP_FLAT) begin
          depth_we = 1'b1;
          color_we = 1'b1;
        end
      end
      B_DSU, B_DSV: div_start = 1'b1;
      B_TEXWR: begin
        depth_we    = 1'b1;
        color_we    = 1'b1;
        color_wdata = tex_rdata;
      end
      B_DONE: out_load = !out_valid_q || out_ready_i;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      job_q       <= '0;
      x_q         <= '0;
      za_q        <= '0;
      ua_q        <= '0;
      va_q        <= '0;
      cnt_q       <= '0;
      clip_q      <= 1'b0;
      tu_q        <= '0;
      tv_q        <= '0;
      opa_q       <= '0;
      rc_q        <= '0;
      rd_q        <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= '{pixel_color: rc_q, pixel_depth: rd_q,
                         pixels_written: cnt_q, status: clip_q};
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_CLEAR: clr_q <= clr_q + 1'b1;
        B_FETCH: begin
          if (!empty_i) begin
            job_q  <= job_i;
            x_q    <= job_i.lo;
            za_q   <= ACC_W'(job_i.z0) <<< 16;
            ua_q   <= ACC_W'(job_i.u0) <<< 16;
            va_q   <= ACC_W'(job_i.v0) <<< 16;
            cnt_q  <= '0;
            clip_q <= job_i.clip;
            rc_q   <= '0;
            rd_q   <= '0;
          end
        end
        B_RWAIT: begin
          rc_q <= color_rdata;
          rd_q <= $signed(depth_rdata);
        end
        B_PIX: begin
          if ({1'b0, x_q} >= cfg_i.sw) begin
            clip_q <= 1'b1;
          end
        end
        B_TEST: begin
          if ($signed(depth_rdata) < zp) begin
            if (job_q.op == OP_FLAT) begin
              cnt_q <= cnt_q + 11'd1;
            end else if (zp == 32'sd0) begin
              clip_q <= 1'b1;
              tu_q   <= '0;
              tv_q   <= '0;
            end
          end
        end
        B_MULU: opa_q <= DIV_DW'(prod_u);
        B_MULV: opa_q <= DIV_DW'(prod_v);
        B_WU: begin
          if (div_done) begin
            if (div_q[DIV_DW-1]) begin
              tu_q   <= '0;
              clip_q <= 1'b1;
            end else if (div_q > tw_lim) begin
              tu_q   <= TCW'(tw_m1);
              clip_q <= 1'b1;
            end else begin
              tu_q <= TCW'(div_q);
            end
          end
        end
        B_WV: begin
          if (div_done) begin
            if (div_q[DIV_DW-1]) begin
              tv_q   <= '0;
              clip_q <= 1'b1;
            end else if (div_q > th_lim) begin
              tv_q   <= TCW'(th_m1);
              clip_q <= 1'b1;
            end else begin
              tv_q <= TCW'(div_q);
            end
          end
        end
        B_TEXWR: cnt_q <= cnt_q + 11'd1;
        B_ADV: begin
          za_q <= za_q + ACC_W'(job_q.zs);
          ua_q <= ua_q + ACC_W'(job_q.us);
          va_q <= va_q + ACC_W'(job_q.vs);
          x_q  <= x_q + 10'd1;
        end
        default: begin
        end
      endcase
    end
  end

  assign clear_done_o = state_q != B_CLEAR;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

`ifndef SYNTHESIS
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == B_WU || state_q == B_WV))
    else $error("divider finished outside a wait state");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("queue popped while empty");
  a_span_write_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_we && (state_q == B_TEST || state_q == B_TEXWR)) |-> ({1'b0, x_q} < cfg_i.sw))
    else $error("span pixel written beyond the screen width");
`endif

endmodule

[src/zbuffered_span_fill_unit.sv]
// Span setup runs three step divisions (z, u, v) in the front end's divider when lo differs
// from hi; the back end then depth-tests each column, and a textured pixel that passes the
// depth test takes two texel divisions in the back end's divider unless its depth is zero.
// One item is in work at a time in each of the front and back ends, with a two-entry queue between.
// After reset the depth and color memories are cleared, one word per cycle, for
// all MAX_SCREEN_WIDTH*MAX_SCREEN_HEIGHT words (1048576 by default) before the first item is taken.
module zbuffered_span_fill_unit import ztf_pkg::*; #(
  parameter int unsigned MAX_SCREEN_WIDTH  = 1024,
  parameter int unsigned MAX_SCREEN_HEIGHT = 1024,
  parameter int unsigned TEXTURE_SLOTS     = 4,
  parameter int unsigned MAX_TEXTURE_SIDE  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [10:0] sw_q, sh_q;
  logic [8:0]  tw_q, th_q;
  logic [10:0] tw_c, th_c;
  cfg_t cfg;

  logic push, pop, full, empty, clear_done;
  job_t job_in, job_out;
  logic [$bits(job_t)-1:0] q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= RST_SCREEN_WIDTH;
      sh_q <= RST_SCREEN_HEIGHT;
      tw_q <= RST_TEXTURE_WIDTH;
      th_q <= RST_TEXTURE_HEIGHT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SCREEN_WIDTH:   sw_q <= cfg_data_i[10:0];
        REG_SCREEN_HEIGHT:  sh_q <= cfg_data_i[10:0];
        REG_TEXTURE_WIDTH:  tw_q <= cfg_data_i[8:0];
        REG_TEXTURE_HEIGHT: th_q <= cfg_data_i[8:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign tw_c   = clamp_cfg({2'b0, tw_q}, MAX_TEXTURE_SIDE);
  assign th_c   = clamp_cfg({2'b0, th_q}, MAX_TEXTURE_SIDE);
  assign cfg.sw = clamp_cfg(sw_q, MAX_SCREEN_WIDTH);
  assign cfg.sh = clamp_cfg(sh_q, MAX_SCREEN_HEIGHT);
  assign cfg.tw = tw_c[8:0];
  assign cfg.th = th_c[8:0];

  ztf_front #(.TEXTURE_SLOTS(TEXTURE_SLOTS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .enable_i   (clear_done),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .full_i     (full),
    .job_o      (job_in)
  );

  ztf_fifo #(.W($bits(job_t)), .DEPTH(Q_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  assign job_out = job_t'(q_rdata);

  ztf_back #(
    .MAX_SCREEN_WIDTH  (MAX_SCREEN_WIDTH),
    .MAX_SCREEN_HEIGHT (MAX_SCREEN_HEIGHT),
    .TEXTURE_SLOTS     (TEXTURE_SLOTS),
    .MAX_TEXTURE_SIDE  (MAX_TEXTURE_SIDE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .empty_i      (empty),
    .job_i        (job_out),
    .pop_o        (pop),
    .clear_done_o (clear_done),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
